// ===== src/stt_pkg.sv =====
package stt_pkg;

    localparam int TURN_W        = 32;
    localparam int Z_W           = 32;
    localparam int PRESCALE_BITS = 16;
    localparam int GUARD_BITS    = 2;
    localparam int TBL_IDX_W     = 5;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SINE_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COSINE_OFFSET = 2'd1;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 32'sh8000_0000;

    localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic                 load;
        logic                 iterate;
        logic                 finish;
        logic [TBL_IDX_W-1:0] step;
    } stt_cmd_t;

    typedef struct packed {
        logic out_busy;
    } stt_status_t;

    // atan(2^-i) as a fraction of a turn, 32 fractional bits
    function automatic logic [Z_W-1:0] atan_turn(input logic [TBL_IDX_W-1:0] idx);
        logic [Z_W-1:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/stt_ctrl.sv =====
module stt_ctrl
    import stt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  stt_status_t status,
    output stt_cmd_t    cmd
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ITER = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.iterate = 1'b0;
        cmd.finish  = 1'b0;
        cmd.step    = TBL_IDX_W'(step_reg);
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.iterate = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the beat
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/stt_datapath.sv =====
module stt_datapath
    import stt_pkg::*;
#(
    parameter int ADC_BITS   = 12,
    parameter int ANGLE_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [ADC_BITS-1:0]         cfg_data,
    input  logic [ADC_BITS-1:0]         sine_sample,
    input  logic [ADC_BITS-1:0]         cosine_sample,
    input  stt_cmd_t                    cmd,
    output stt_status_t                 status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ANGLE_BITS-1:0]       angle,
    output logic signed [TURN_W-1:0]    turn_count
);

    localparam int DW = ADC_BITS + 1 + PRESCALE_BITS + GUARD_BITS;
    localparam logic [ADC_BITS-1:0] MID_SCALE = {1'b1, {(ADC_BITS-1){1'b0}}};
    localparam logic [Z_W-1:0] ROUND_BIT = Z_W'(1) << (Z_W - 1 - ANGLE_BITS);
    localparam logic signed [ANGLE_BITS:0] HALF     = {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS:0] NEG_HALF = {2'b11, {(ANGLE_BITS-1){1'b0}}};

    logic [ADC_BITS-1:0]          sine_off_reg, cosine_off_reg;
    logic signed [DW-1:0]         x_reg, x_next;
    logic signed [DW-1:0]         y_reg, y_next;
    logic [Z_W-1:0]               z_reg, z_next;
    logic                         zero_reg;
    logic [ANGLE_BITS-1:0]        prev_angle_reg;
    logic signed [TURN_W-1:0]     turns_reg, turns_next;
    logic                         first_reg;
    logic                         out_valid_reg;
    logic [ANGLE_BITS-1:0]        angle_reg, angle_next;
    logic signed [TURN_W-1:0]     turn_out_reg;

    logic signed [ADC_BITS:0]     diff_y, diff_x;
    logic signed [DW-1:0]         y_load, x_load;
    logic signed [DW-1:0]         dx, dy;
    logic                         y_pos;
    logic [Z_W-1:0]               atan_val, z_round;
    logic signed [ANGLE_BITS:0]   delta;

    assign diff_y = $signed({1'b0, sine_sample}) - $signed({1'b0, sine_off_reg});
    assign diff_x = $signed({1'b0, cosine_sample}) - $signed({1'b0, cosine_off_reg});
    assign y_load = {{GUARD_BITS{diff_y[ADC_BITS]}}, diff_y, {PRESCALE_BITS{1'b0}}};
    assign x_load = {{GUARD_BITS{diff_x[ADC_BITS]}}, diff_x, {PRESCALE_BITS{1'b0}}};

    assign dx       = y_reg >>> cmd.step;
    assign dy       = x_reg >>> cmd.step;
    assign y_pos    = !y_reg[DW-1] && (y_reg != '0);
    assign atan_val = atan_turn(cmd.step);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.load)
        begin
            // left half plane: rotate by half a turn first
            if (diff_x[ADC_BITS])
            begin
                x_next = -x_load;
                y_next = -y_load;
                z_next = HALF_TURN;
            end
            else
            begin
                x_next = x_load;
                y_next = y_load;
                z_next = '0;
            end
        end
        else if (cmd.iterate)
        begin
            if (y_pos)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_val;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_val;
            end
        end
    end

    assign z_round    = z_reg + ROUND_BIT;
    assign angle_next = zero_reg ? '0 : z_round[Z_W-1 -: ANGLE_BITS];
    assign delta      = $signed({1'b0, angle_next}) - $signed({1'b0, prev_angle_reg});

    always_comb
    begin
        turns_next = turns_reg;
        if (!first_reg)
        begin
            if (delta > HALF)
            begin
                if (turns_reg != TURN_MIN)
                begin
                    turns_next = turns_reg - 1'b1;
                end
            end
            else if (delta < NEG_HALF)
            begin
                if (turns_reg != TURN_MAX)
                begin
                    turns_next = turns_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_off_reg   <= MID_SCALE;
            cosine_off_reg <= MID_SCALE;
            prev_angle_reg <= '0;
            turns_reg      <= '0;
            first_reg      <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_SINE_OFFSET:   sine_off_reg   <= cfg_data;
                    REG_COSINE_OFFSET: cosine_off_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.finish)
            begin
                prev_angle_reg <= angle_next;
                turns_reg      <= turns_next;
                first_reg      <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.load)
        begin
            zero_reg <= (diff_x == '0) && (diff_y == '0);
        end
        if (cmd.finish)
        begin
            angle_reg    <= angle_next;
            turn_out_reg <= turns_next;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign angle           = angle_reg;
    assign turn_count      = turn_out_reg;

endmodule

// ===== src/sincos_angle_turn_tracker.sv =====
// Sine/cosine sensor angle decoder with turn counter.
// Input channel (in_valid/in_ready) takes one beat of raw ADC samples; the
// zero offsets of both channels are removed and atan2 is found by an
// iterative vectoring CORDIC, one micro-rotation per cycle on one shared
// shift/add unit. Output channel (out_valid/out_ready) gives one beat per
// input beat: the angle (2^ANGLE_BITS units per turn) and the saturating
// signed turn count, which moves by one when the angle wraps across zero.
// After an input beat the controller runs the CORDIC iteration loop
// (S_ITER), then in S_DONE registers the result and raises out_valid. No
// new beat is taken until that is done; in_ready is high only between items.
// The result sits in an output register, so the next input beat is taken
// while a finished result still waits. If the receiver stalls, the block
// holds its next result until the output register frees.
// Offsets are written via cfg_write_en/cfg_index/cfg_data (index 0 sine, 1 cosine,
// others ignored); the user must write them only while the block is idle, as the block does not enforce it.
// Reset: offsets go to mid-scale, turn count to zero, and the first beat
// after reset only records its angle.
module sincos_angle_turn_tracker
    import stt_pkg::*;
#(
    parameter int ADC_BITS     = 12,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [ADC_BITS-1:0]         cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ADC_BITS-1:0]         sine_sample,
    input  logic [ADC_BITS-1:0]         cosine_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ANGLE_BITS-1:0]       angle,
    output logic signed [TURN_W-1:0]    turn_count
);

    stt_cmd_t    cmd;
    stt_status_t status;

    stt_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    stt_datapath #(
        .ADC_BITS   (ADC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sine_sample   (sine_sample),
        .cosine_sample (cosine_sample),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .angle         (angle),
        .turn_count    (turn_count)
    );

endmodule
